@@ src/sgc_pkg.sv @@
// types, codes and helper functions shared by the swing gate controller modules
package sgc_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_TOGGLE = 3'd2;
    localparam logic [2:0] OP_OPEN   = 3'd3;
    localparam logic [2:0] OP_CLOSE  = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;

    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_OPENING = 3'd2;
    localparam logic [2:0] ST_OPEN    = 3'd3;
    localparam logic [2:0] ST_CLOSING = 3'd4;

    localparam logic [1:0] RL_NONE  = 2'd0;
    localparam logic [1:0] RL_OPEN  = 2'd1;
    localparam logic [1:0] RL_CLOSE = 2'd2;
    localparam logic [1:0] RL_STOP  = 2'd3;

    localparam logic [2:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] CFG_RELAY_PULSE  = 3'd1;
    localparam logic [2:0] CFG_OPEN_TRAVEL  = 3'd2;
    localparam logic [2:0] CFG_CLOSE_TRAVEL = 3'd3;
    localparam logic [2:0] CFG_BOOT_SETTLE  = 3'd4;
    localparam logic [2:0] CFG_BLINK_GAP    = 3'd5;
    localparam logic [2:0] CFG_NOTIFY_GAP   = 3'd6;
    localparam logic [2:0] CFG_NOTIFY_EN    = 3'd7;

    localparam logic [15:0] RST_DEBOUNCE     = 16'd50;
    localparam logic [15:0] RST_RELAY_PULSE  = 16'd500;
    localparam logic [15:0] RST_OPEN_TRAVEL  = 16'd20000;
    localparam logic [15:0] RST_CLOSE_TRAVEL = 16'd30000;
    localparam logic [15:0] RST_BOOT_SETTLE  = 16'd20000;
    localparam logic [15:0] RST_BLINK_GAP    = 16'd1500;
    localparam logic [15:0] RST_NOTIFY_GAP   = 16'd500;

    typedef struct packed {
        logic [2:0] op;
        logic       lock_pin;
        logic       lights_pin;
        logic       photo_eye_pin;
        logic       ext_relay_pin;
    } t_in;

    typedef struct packed {
        logic [2:0] gate_state;
        logic [1:0] relay_drive;
        logic       in_motion;
        logic       lock_level;
        logic       lights_level;
        logic       photo_eye_level;
        logic       ext_relay_level;
        logic       notify;
        logic       command_taken;
    } t_out;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] relay_pulse_ms;
        logic [15:0] open_travel_ms;
        logic [15:0] close_travel_ms;
        logic [15:0] boot_settle_ms;
        logic [15:0] blink_gap_ms;
        logic [15:0] notify_gap_ms;
        logic        notify_enable;
    } t_cfg;

    // valid gate state transitions
    function automatic logic f_allowed(input logic [2:0] from, input logic [2:0] to);
        logic ok;
        case (from)
            ST_UNKNOWN: ok = (to == ST_CLOSED) || (to == ST_OPEN) ||
                             (to == ST_OPENING) || (to == ST_CLOSING);
            ST_CLOSED:  ok = (to == ST_OPENING) || (to == ST_UNKNOWN);
            ST_OPENING: ok = (to == ST_OPEN) || (to == ST_CLOSED) || (to == ST_UNKNOWN);
            ST_OPEN:    ok = (to == ST_CLOSING) || (to == ST_CLOSED) || (to == ST_UNKNOWN);
            ST_CLOSING: ok = (to == ST_CLOSED) || (to == ST_OPEN) || (to == ST_UNKNOWN);
            default:    ok = 1'b0;
        endcase
        return ok;
    endfunction

    // a state change takes effect only when it differs and is allowed
    function automatic logic f_go(input logic [2:0] from, input logic [2:0] to);
        return (from != to) && f_allowed(from, to);
    endfunction

endpackage

@@ src/sgc_cfg_regs.sv @@
// configuration register file of the swing gate controller
module sgc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [2:0]    i_index,
    input  logic [15:0]   i_data,
    output sgc_pkg::t_cfg o_cfg
);
    import sgc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= RST_DEBOUNCE;
            r_cfg.relay_pulse_ms  <= RST_RELAY_PULSE;
            r_cfg.open_travel_ms  <= RST_OPEN_TRAVEL;
            r_cfg.close_travel_ms <= RST_CLOSE_TRAVEL;
            r_cfg.boot_settle_ms  <= RST_BOOT_SETTLE;
            r_cfg.blink_gap_ms    <= RST_BLINK_GAP;
            r_cfg.notify_gap_ms   <= RST_NOTIFY_GAP;
            r_cfg.notify_enable   <= 1'b0;
        end else if (i_wr) begin
            case (i_index)
                CFG_DEBOUNCE:     r_cfg.debounce_ms     <= i_data;
                CFG_RELAY_PULSE:  r_cfg.relay_pulse_ms  <= i_data;
                CFG_OPEN_TRAVEL:  r_cfg.open_travel_ms  <= i_data;
                CFG_CLOSE_TRAVEL: r_cfg.close_travel_ms <= i_data;
                CFG_BOOT_SETTLE:  r_cfg.boot_settle_ms  <= i_data;
                CFG_BLINK_GAP:    r_cfg.blink_gap_ms    <= i_data;
                CFG_NOTIFY_GAP:   r_cfg.notify_gap_ms   <= i_data;
                CFG_NOTIFY_EN:    r_cfg.notify_enable   <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/sgc_core.sv @@
// controller state registers and the per-request update logic
module sgc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  sgc_pkg::t_in  i_item,
    input  sgc_pkg::t_cfg i_cfg,
    output sgc_pkg::t_out o_res
);
    import sgc_pkg::*;

    logic [31:0] r_now, n_now;
    logic        r_started, n_started;
    logic [2:0]  r_state, n_state;
    logic [3:0]  r_lvl, n_lvl;
    logic [31:0] r_sct [4];
    logic [31:0] n_sct [4];
    logic [31:0] r_stc, n_stc;
    logic        r_relay_on, n_relay_on;
    logic [1:0]  r_relay_which, n_relay_which;
    logic [31:0] r_rst, n_rst;
    logic        r_motion, n_motion;
    logic [31:0] r_lht, n_lht;
    logic [31:0] r_nt, n_nt;

    logic [3:0]  lv;
    logic        changed;
    logic        note;
    logic        taken;
    logic        do_fire;
    logic        has_tgt;
    logic [1:0]  fire_which;
    logic [2:0]  tgt;
    logic        ext;

    assign lv = ~{i_item.ext_relay_pin, i_item.photo_eye_pin, i_item.lights_pin,
                  i_item.lock_pin};

    always_comb begin
        n_now         = r_now;
        n_started     = r_started;
        n_state       = r_state;
        n_lvl         = r_lvl;
        n_sct         = r_sct;
        n_stc         = r_stc;
        n_relay_on    = r_relay_on;
        n_relay_which = r_relay_which;
        n_rst         = r_rst;
        n_motion      = r_motion;
        n_lht         = r_lht;
        n_nt          = r_nt;
        changed       = 1'b0;
        note          = 1'b0;
        taken         = 1'b0;
        do_fire       = 1'b0;
        has_tgt       = 1'b0;
        fire_which    = RL_NONE;
        tgt           = ST_UNKNOWN;
        ext           = 1'b0;

        case (i_item.op)
            OP_TICK: begin
                n_now = r_now + 32'd1;
                if (r_started) begin
                    // debounce with lockout after each change
                    for (int i = 0; i < 4; i++) begin
                        if (((n_now - r_sct[i]) >= {16'd0, i_cfg.debounce_ms}) &&
                            (lv[i] != r_lvl[i])) begin
                            n_lvl[i] = lv[i];
                            n_sct[i] = n_now;
                            changed  = 1'b1;
                        end
                    end
                    // motion follows the blinking light
                    if (n_lvl[1]) begin
                        n_lht    = n_now;
                        n_motion = 1'b1;
                    end else if (r_motion &&
                                 ((n_now - r_lht) >= {16'd0, i_cfg.blink_gap_ms})) begin
                        n_motion = 1'b0;
                    end
                    // relay auto release
                    if (r_relay_on && ((n_now - r_rst) >= {16'd0, i_cfg.relay_pulse_ms})) begin
                        n_relay_on    = 1'b0;
                        n_relay_which = RL_NONE;
                        n_rst         = 32'd0;
                    end
                    // gate machine
                    ext = n_lvl[3];
                    has_tgt = 1'b1;
                    case (r_state)
                        ST_UNKNOWN: begin
                            if (!ext) begin
                                tgt = ST_CLOSED;
                            end else if ((n_now - r_stc) >= {16'd0, i_cfg.boot_settle_ms}) begin
                                tgt = ST_OPEN;
                            end else begin
                                has_tgt = 1'b0;
                            end
                        end
                        ST_CLOSED: begin
                            if (ext) begin
                                tgt = ST_OPENING;
                            end else begin
                                has_tgt = 1'b0;
                            end
                        end
                        ST_OPENING: begin
                            if (!ext) begin
                                tgt = ST_CLOSED;
                            end else if ((n_now - r_stc) >= {16'd0, i_cfg.open_travel_ms}) begin
                                tgt = ST_OPEN;
                            end else begin
                                has_tgt = 1'b0;
                            end
                        end
                        ST_OPEN: begin
                            if (!ext) begin
                                tgt = ST_CLOSED;
                            end else begin
                                has_tgt = 1'b0;
                            end
                        end
                        ST_CLOSING: begin
                            if (!ext) begin
                                tgt = ST_CLOSED;
                            end else if ((n_now - r_stc) >= {16'd0, i_cfg.close_travel_ms}) begin
                                tgt = ST_OPEN;
                            end else begin
                                has_tgt = 1'b0;
                            end
                        end
                        default: has_tgt = 1'b0;
                    endcase
                    if (has_tgt && f_go(r_state, tgt)) begin
                        n_state = tgt;
                        n_stc   = n_now;
                    end
                    // rate-limited change pulse
                    if (changed && i_cfg.notify_enable &&
                        ((n_now - r_nt) >= {16'd0, i_cfg.notify_gap_ms})) begin
                        n_nt = n_now;
                        note = 1'b1;
                    end
                end
            end
            OP_START: begin
                n_lvl     = lv;
                for (int i = 0; i < 4; i++) begin
                    n_sct[i] = r_now;
                end
                n_started = 1'b1;
                n_stc     = r_now;
                tgt       = lv[0] ? ST_CLOSED : ST_UNKNOWN;
                if (f_go(r_state, tgt)) begin
                    n_state = tgt;
                end
            end
            OP_TOGGLE: begin
                if (r_started && !r_relay_on &&
                    (r_state != ST_OPENING) && (r_state != ST_CLOSING)) begin
                    case (r_state)
                        ST_CLOSED: begin
                            do_fire = 1'b1;
                            has_tgt = 1'b1;
                        end
                        ST_OPEN: begin
                            do_fire = 1'b1;
                            has_tgt = 1'b1;
                        end
                        ST_UNKNOWN: begin
                            // settle to a known end first, then move away from it
                            tgt = r_lvl[0] ? ST_CLOSED : ST_OPEN;
                            if (f_go(r_state, tgt)) begin
                                n_state = tgt;
                                n_stc   = r_now;
                            end
                            do_fire = 1'b1;
                            has_tgt = 1'b1;
                        end
                        default: ;
                    endcase
                    if (n_state == ST_CLOSED) begin
                        fire_which = RL_OPEN;
                        tgt        = ST_OPENING;
                    end else begin
                        fire_which = RL_CLOSE;
                        tgt        = ST_CLOSING;
                    end
                end
            end
            OP_OPEN: begin
                do_fire    = r_started;
                has_tgt    = 1'b1;
                fire_which = RL_OPEN;
                tgt        = ST_OPENING;
            end
            OP_CLOSE: begin
                do_fire    = r_started;
                has_tgt    = 1'b1;
                fire_which = RL_CLOSE;
                tgt        = ST_CLOSING;
            end
            OP_STOP: begin
                do_fire    = r_started;
                fire_which = RL_STOP;
            end
            default: ;
        endcase

        // relay fire for command requests
        if (do_fire && !r_relay_on) begin
            n_relay_on    = 1'b1;
            n_relay_which = fire_which;
            n_rst         = r_now;
            taken         = 1'b1;
            if (has_tgt && f_go(n_state, tgt)) begin
                n_state = tgt;
                n_stc   = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= 32'd0;
            r_started     <= 1'b0;
            r_state       <= ST_UNKNOWN;
            r_lvl         <= 4'd0;
            r_sct         <= '{default: 32'd0};
            r_stc         <= 32'd0;
            r_relay_on    <= 1'b0;
            r_relay_which <= RL_NONE;
            r_rst         <= 32'd0;
            r_motion      <= 1'b0;
            r_lht         <= 32'd0;
            r_nt          <= 32'd0;
        end else if (i_step) begin
            r_now         <= n_now;
            r_started     <= n_started;
            r_state       <= n_state;
            r_lvl         <= n_lvl;
            r_sct         <= n_sct;
            r_stc         <= n_stc;
            r_relay_on    <= n_relay_on;
            r_relay_which <= n_relay_which;
            r_rst         <= n_rst;
            r_motion      <= n_motion;
            r_lht         <= n_lht;
            r_nt          <= n_nt;
        end
    end

    always_comb begin
        o_res.gate_state      = n_state;
        o_res.relay_drive     = n_relay_on ? n_relay_which : RL_NONE;
        o_res.in_motion       = n_motion;
        o_res.lock_level      = n_lvl[0];
        o_res.lights_level    = n_lvl[1];
        o_res.photo_eye_level = n_lvl[2];
        o_res.ext_relay_level = n_lvl[3];
        o_res.notify          = note;
        o_res.command_taken   = taken;
    end

endmodule

@@ src/swing_gate_controller_top.sv @@
// swing gate controller top level: request and result registers around the core
// Takes one request (millisecond tick or gate command) per clock while the result
// is not stalled and returns one result per request. The rate is set by the update
// of the controller state registers between the request register and the result
// register; a stalled result holds the pipeline, and the request register keeps
// accepting while the result register is free. Configuration writes are always
// ready and are meant for idle periods.
module swing_gate_controller_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sgc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sgc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import sgc_pkg::*;

    t_in   r_in;
    logic  r_in_valid;
    t_out  r_out;
    logic  r_out_valid;
    t_cfg  cfg;
    t_out  res;
    logic  advance;
    logic  step;

    assign advance     = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    sgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sgc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ tb/sv/swing_gate_controller_top_tb.sv @@
// testbench for the swing gate controller: directed and random requests checked against a predictor
module swing_gate_controller_top_tb;
    import sgc_pkg::*;

    localparam logic [2:0]  OP_SPARE_A  = 3'd6;
    localparam logic [2:0]  OP_SPARE_B  = 3'd7;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned MAX_REPORTS = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in         in_req    = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    t_in         pending_reqs[$];
    t_out        expected_status[$];
    t_out        want;
    logic [3:0]  pin_levels   = 4'b1111;
    bit          calm         = 1'b0;
    int unsigned req_gap      = 0;
    int unsigned rsp_stall    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned queued_total = 0;
    int unsigned results_seen = 0;
    int          failures     = 0;

    // predictor state, index 0 lock, 1 lights, 2 photo eye, 3 external relay
    t_cfg        live_cfg = '{debounce_ms: RST_DEBOUNCE, relay_pulse_ms: RST_RELAY_PULSE,
                              open_travel_ms: RST_OPEN_TRAVEL, close_travel_ms: RST_CLOSE_TRAVEL,
                              boot_settle_ms: RST_BOOT_SETTLE, blink_gap_ms: RST_BLINK_GAP,
                              notify_gap_ms: RST_NOTIFY_GAP, notify_enable: 1'b0};
    logic [31:0] ms_now        = '0;
    bit          run_started   = 1'b0;
    logic [2:0]  gate_now      = ST_UNKNOWN;
    logic [3:0]  sensed        = '0;
    logic [31:0] sensed_at [4] = '{default: '0};
    logic [31:0] gate_since    = '0;
    bit          relay_busy    = 1'b0;
    logic [1:0]  relay_kind    = RL_NONE;
    logic [31:0] relay_since   = '0;
    bit          moving        = 1'b0;
    logic [31:0] light_seen_at = '0;
    logic [31:0] notify_at     = '0;

    swing_gate_controller_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] elapsed(input logic [31:0] stamp);
        return ms_now - stamp;
    endfunction

    function automatic void move_to(input logic [2:0] target);
        bit ok;
        case (gate_now)
            ST_UNKNOWN: ok = 1'b1;
            ST_CLOSED:  ok = (target == ST_OPENING) || (target == ST_UNKNOWN);
            ST_OPENING: ok = (target != ST_CLOSING);
            default:    ok = (target != ST_OPENING);
        endcase
        if (ok && target != gate_now) begin
            gate_now   = target;
            gate_since = ms_now;
        end
    endfunction

    function automatic bit fire_relay(input logic [1:0] kind);
        if (relay_busy) return 1'b0;
        relay_busy  = 1'b1;
        relay_kind  = kind;
        relay_since = ms_now;
        return 1'b1;
    endfunction

    function automatic bit drive_gate(input logic [1:0] kind, input logic [2:0] target);
        if (!fire_relay(kind)) return 1'b0;
        move_to(target);
        return 1'b1;
    endfunction

    function automatic bit sample_pin(input int idx, input logic active);
        if (elapsed(sensed_at[idx]) < live_cfg.debounce_ms || active == sensed[idx]) return 1'b0;
        sensed[idx]    = active;
        sensed_at[idx] = ms_now;
        return 1'b1;
    endfunction

    function automatic t_out predict_status(input t_in req);
        logic [3:0] act;
        bit         changed;
        bit         note;
        bit         taken;
        t_out       res;
        act     = ~{req.ext_relay_pin, req.photo_eye_pin, req.lights_pin, req.lock_pin};
        changed = 1'b0;
        note    = 1'b0;
        taken   = 1'b0;
        case (req.op)
            OP_TICK: begin
                ms_now = ms_now + 32'd1;
                if (run_started) begin
                    if (sample_pin(0, act[0])) changed = 1'b1;
                    if (sample_pin(1, act[1])) changed = 1'b1;
                    if (sensed[1]) begin
                        light_seen_at = ms_now;
                        moving        = 1'b1;
                    end else if (moving && elapsed(light_seen_at) >= live_cfg.blink_gap_ms) begin
                        moving = 1'b0;
                    end
                    if (sample_pin(2, act[2])) changed = 1'b1;
                    if (sample_pin(3, act[3])) changed = 1'b1;
                    if (relay_busy && elapsed(relay_since) >= live_cfg.relay_pulse_ms) begin
                        relay_busy  = 1'b0;
                        relay_kind  = RL_NONE;
                        relay_since = '0;
                    end
                    case (gate_now)
                        ST_UNKNOWN: begin
                            if (!sensed[3]) move_to(ST_CLOSED);
                            else if (elapsed(gate_since) >= live_cfg.boot_settle_ms) move_to(ST_OPEN);
                        end
                        ST_CLOSED: begin
                            if (sensed[3]) move_to(ST_OPENING);
                        end
                        ST_OPENING: begin
                            if (!sensed[3]) move_to(ST_CLOSED);
                            else if (elapsed(gate_since) >= live_cfg.open_travel_ms) move_to(ST_OPEN);
                        end
                        ST_OPEN: begin
                            if (!sensed[3]) move_to(ST_CLOSED);
                        end
                        ST_CLOSING: begin
                            if (!sensed[3]) move_to(ST_CLOSED);
                            else if (elapsed(gate_since) >= live_cfg.close_travel_ms) move_to(ST_OPEN);
                        end
                        default: ;
                    endcase
                    if (changed && live_cfg.notify_enable &&
                        elapsed(notify_at) >= live_cfg.notify_gap_ms) begin
                        notify_at = ms_now;
                        note      = 1'b1;
                    end
                end
            end
            OP_START: begin
                sensed = act;
                for (int i = 0; i < 4; i++) sensed_at[i] = ms_now;
                run_started = 1'b1;
                gate_since  = ms_now;
                move_to(act[0] ? ST_CLOSED : ST_UNKNOWN);
            end
            OP_TOGGLE: begin
                if (run_started && gate_now != ST_OPENING && gate_now != ST_CLOSING && !relay_busy) begin
                    case (gate_now)
                        ST_CLOSED: taken = drive_gate(RL_OPEN, ST_OPENING);
                        ST_OPEN:   taken = drive_gate(RL_CLOSE, ST_CLOSING);
                        ST_UNKNOWN: begin
                            if (sensed[0]) begin
                                move_to(ST_CLOSED);
                                taken = drive_gate(RL_OPEN, ST_OPENING);
                            end else begin
                                move_to(ST_OPEN);
                                taken = drive_gate(RL_CLOSE, ST_CLOSING);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_OPEN:  if (run_started) taken = drive_gate(RL_OPEN, ST_OPENING);
            OP_CLOSE: if (run_started) taken = drive_gate(RL_CLOSE, ST_CLOSING);
            OP_STOP:  if (run_started) taken = fire_relay(RL_STOP);
            default: ;
        endcase
        res.gate_state      = gate_now;
        res.relay_drive     = relay_busy ? relay_kind : RL_NONE;
        res.in_motion       = moving;
        res.lock_level      = sensed[0];
        res.lights_level    = sensed[1];
        res.photo_eye_level = sensed[2];
        res.ext_relay_level = sensed[3];
        res.notify          = note;
        res.command_taken   = taken;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            req_gap  <= 0;
        end else begin
            if (in_valid && in_ready) expected_status.push_back(predict_status(in_req));
            if (!in_valid || in_ready) begin
                if (req_gap != 0) begin
                    in_valid <= 1'b0;
                    req_gap  <= req_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    in_valid <= 1'b1;
                    in_req   <= pending_reqs.pop_front();
                    req_gap  <= calm ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rsp_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_status.size() == 0) begin
                    if (failures < MAX_REPORTS)
                        $display("unexpected result %h at %0t", out_res, $realtime);
                    failures <= failures + 1;
                end else begin
                    want = expected_status.pop_front();
                    if (out_res !== want) begin
                        if (failures < MAX_REPORTS) begin
                            $display("mismatch at %0t (state/relay/motion/levels/notify/taken)",
                                     $realtime);
                            $display("    expected %0d/%0d/%b/%b%b%b%b/%b/%b",
                                     want.gate_state, want.relay_drive, want.in_motion,
                                     want.lock_level, want.lights_level, want.photo_eye_level,
                                     want.ext_relay_level, want.notify, want.command_taken);
                            $display("    got      %0d/%0d/%b/%b%b%b%b/%b/%b",
                                     out_res.gate_state, out_res.relay_drive, out_res.in_motion,
                                     out_res.lock_level, out_res.lights_level,
                                     out_res.photo_eye_level, out_res.ext_relay_level,
                                     out_res.notify, out_res.command_taken);
                        end
                        failures <= failures + 1;
                    end
                end
            end
            if (rsp_stall != 0) begin
                out_ready <= 1'b0;
                rsp_stall <= rsp_stall - 1;
            end else begin
                out_ready <= 1'b1;
                rsp_stall <= calm ? 0 : pick_gap();
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_req(input logic [2:0] op, input logic [3:0] pins);
        pending_reqs.push_back(t_in'({op, pins}));
        queued_total++;
    endtask

    task automatic settle();
        while (results_seen != queued_total) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        logic [2:0]  idx;
        logic [15:0] val;
        for (int k = 0; k < 8; k++) begin
            idx = 3'(k);
            case (idx)
                CFG_DEBOUNCE:     val = c.debounce_ms;
                CFG_RELAY_PULSE:  val = c.relay_pulse_ms;
                CFG_OPEN_TRAVEL:  val = c.open_travel_ms;
                CFG_CLOSE_TRAVEL: val = c.close_travel_ms;
                CFG_BOOT_SETTLE:  val = c.boot_settle_ms;
                CFG_BLINK_GAP:    val = c.blink_gap_ms;
                CFG_NOTIFY_GAP:   val = c.notify_gap_ms;
                CFG_NOTIFY_EN:    val = {15'($urandom), c.notify_enable};
                default:          val = '0;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge i_clk); while (!cfg_ready);
            case (idx)
                CFG_DEBOUNCE:     live_cfg.debounce_ms     = val;
                CFG_RELAY_PULSE:  live_cfg.relay_pulse_ms  = val;
                CFG_OPEN_TRAVEL:  live_cfg.open_travel_ms  = val;
                CFG_CLOSE_TRAVEL: live_cfg.close_travel_ms = val;
                CFG_BOOT_SETTLE:  live_cfg.boot_settle_ms  = val;
                CFG_BLINK_GAP:    live_cfg.blink_gap_ms    = val;
                CFG_NOTIFY_GAP:   live_cfg.notify_gap_ms   = val;
                CFG_NOTIFY_EN:    live_cfg.notify_enable   = val[0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly ticks with slowly moving pins, blinking light, some commands and glitches
    task automatic queue_random(input int unsigned count);
        logic [2:0]  op;
        logic [3:0]  drive;
        int unsigned r;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 2) op = OP_START;
            else if (r < 4) op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
            else if (r < 18) op = 3'($urandom_range(OP_TOGGLE, OP_STOP));
            else op = OP_TICK;
            if ($urandom_range(99) < 25) pin_levels[2] = ~pin_levels[2];
            if ($urandom_range(99) < 6) pin_levels[0] = ~pin_levels[0];
            if ($urandom_range(99) < 4) pin_levels[3] = ~pin_levels[3];
            if ($urandom_range(99) < 4) pin_levels[1] = ~pin_levels[1];
            drive = ($urandom_range(99) < 3) ? 4'($urandom) : pin_levels;
            queue_req(op, drive);
        end
    endtask

    task automatic run_phase(input t_cfg c, input bit quiet, input int unsigned count);
        settle();
        program_regs(c);
        calm <= quiet;
        queue_random(count);
    endtask

    initial begin
        t_cfg setting;
        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before start: commands and spare codes do nothing
        queue_req(OP_TICK, 4'b0000);
        queue_req(OP_TOGGLE, 4'b0000);
        queue_req(OP_OPEN, 4'b0000);
        queue_req(OP_CLOSE, 4'b0000);
        queue_req(OP_STOP, 4'b0000);
        queue_req(OP_SPARE_A, 4'b0000);
        // start with lock inactive, then the gate closes on an inactive external relay
        queue_req(OP_START, 4'b1111);
        queue_req(OP_TICK, 4'b1111);
        queue_req(OP_TOGGLE, 4'b1111);
        // relay busy: further commands refused, toggle ignored while opening
        queue_req(OP_OPEN, 4'b1111);
        queue_req(OP_CLOSE, 4'b1111);
        queue_req(OP_STOP, 4'b1111);
        queue_req(OP_TOGGLE, 4'b1111);
        queue_req(OP_SPARE_B, 4'b1010);
        // repeated start with every sensor active
        queue_req(OP_START, 4'b0000);
        queue_req(OP_TICK, 4'b0000);
        queue_req(OP_TICK, 4'b1111);
        queue_req(OP_TICK, 4'b0101);

        setting = '{debounce_ms: 16'd2, relay_pulse_ms: 16'd3, open_travel_ms: 16'd12,
                    close_travel_ms: 16'd15, boot_settle_ms: 16'd10, blink_gap_ms: 16'd6,
                    notify_gap_ms: 16'd4, notify_enable: 1'b1};
        run_phase(setting, 1'b0, 300);

        setting = '0;
        setting.notify_enable = 1'b1;
        run_phase(setting, 1'b1, 250);

        setting = '1;
        run_phase(setting, 1'b0, 150);

        for (int pass_no = 0; pass_no < 3; pass_no++) begin
            setting.debounce_ms     = 16'($urandom_range(0, 6));
            setting.relay_pulse_ms  = 16'($urandom_range(0, 8));
            setting.open_travel_ms  = 16'($urandom_range(1, 30));
            setting.close_travel_ms = 16'($urandom_range(1, 30));
            setting.boot_settle_ms  = 16'($urandom_range(1, 40));
            setting.blink_gap_ms    = 16'($urandom_range(1, 12));
            setting.notify_gap_ms   = 16'($urandom_range(0, 10));
            setting.notify_enable   = 1'($urandom_range(1));
            run_phase(setting, pass_no == 1, 280);
        end

        setting = '{debounce_ms: 16'd1, relay_pulse_ms: 16'd5, open_travel_ms: 16'd25,
                    close_travel_ms: 16'd25, boot_settle_ms: 16'd30, blink_gap_ms: 16'd8,
                    notify_gap_ms: 16'd0, notify_enable: 1'b0};
        run_phase(setting, 1'b0, 200);

        settle();
        if (failures == 0 && expected_status.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
